// File: hw/rtl/twsu_pkg.sv
// Shared types and constants of the trailing day weather summary unit.
package twsu_pkg;

  localparam int unsigned HistDepthDef = 32;

  localparam int unsigned TsW    = 32;
  localparam int unsigned TempW  = 12;
  localparam int unsigned HumW   = 10;
  localparam int unsigned PcpW   = 12;
  localparam int unsigned SolarW = 12;
  localparam int unsigned WinW   = 20;
  localparam int unsigned SlimW  = 11;
  localparam int unsigned PsumW  = 17;
  localparam int unsigned CntOutW = 6;

  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 20;

  localparam int unsigned InDataW  = 80;
  localparam int unsigned OutDataW = 64;

  localparam logic [CfgIdxW-1:0] CFG_WINDOW = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_HFLOOR = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_SLIMIT = 2'd2;

  localparam logic [WinW-1:0]  WindowRst = 20'd86400;
  localparam logic [HumW-1:0]  HfloorRst = 10'd10;
  localparam logic [SlimW-1:0] SlimitRst = 11'd2000;

  localparam logic signed [TempW-1:0] TempLoExcl = -12'sd760;
  localparam logic signed [TempW-1:0] TempHiExcl = 12'sd1400;
  localparam logic [HumW-1:0]         HumMax     = 10'd1000;
  localparam logic [PsumW-1:0]        PsumMax    = 17'd131071;

  typedef struct packed {
    logic [WinW-1:0]  window;
    logic [HumW-1:0]  hfloor;
    logic [SlimW-1:0] slimit;
  } cfg_t;

  typedef struct packed {
    logic [PcpW-1:0]  pcp;
    logic [HumW-1:0]  hum;
    logic [TempW-1:0] temp;
    logic [TsW-1:0]   ts;
  } hist_t;

  localparam int unsigned HistW = $bits(hist_t);

  typedef struct packed {
    logic load;
    logic add;
  } acc_ctl_t;

endpackage

// File: hw/rtl/twsu_ram.sv
// Generic simple dual-port RAM with registered read.
module twsu_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 32,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

// File: hw/rtl/twsu_cfg.sv
// Configuration registers of the weather summary unit.
module twsu_cfg
  import twsu_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  output cfg_t                cfg_o
);

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_WINDOW: cfg_d.window = cfg_wdata_i[WinW-1:0];
        CFG_HFLOOR: cfg_d.hfloor = cfg_wdata_i[HumW-1:0];
        CFG_SLIMIT: cfg_d.slimit = cfg_wdata_i[SlimW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.window <= WindowRst;
      cfg_q.hfloor <= HfloorRst;
      cfg_q.slimit <= SlimitRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// File: hw/rtl/twsu_accum.sv
// Window accumulators: age test, min/max, humidity minimum, saturating sum, count.
module twsu_accum
  import twsu_pkg::*;
#(
  parameter int unsigned HISTORY_DEPTH = HistDepthDef,
  localparam int unsigned CntW = $clog2(HISTORY_DEPTH + 1)
) (
  input  logic              clk_i,
  input  acc_ctl_t          ctl_i,
  input  hist_t             cur_i,
  input  hist_t             ent_i,
  input  logic [WinW-1:0]   window_i,
  output logic              too_old_o,
  output logic [TempW-1:0]  tmin_o,
  output logic [TempW-1:0]  tmax_o,
  output logic [HumW-1:0]   hmin_o,
  output logic [PsumW-1:0]  psum_o,
  output logic [CntW-1:0]   cnt_o
);

  logic [TsW-1:0]   ts_q;
  logic [TempW-1:0] tmin_q, tmax_q;
  logic [HumW-1:0]  hmin_q;
  logic [PsumW-1:0] psum_q;
  logic [CntW-1:0]  cnt_q;
  logic [TsW:0]     age;
  logic [PsumW:0]   psum_sum;

  // signed age: a negative difference is always inside the window
  assign age       = {1'b0, ts_q} - {1'b0, ent_i.ts};
  assign too_old_o = !age[TsW] && (age[TsW-1:0] >= {{(TsW-WinW){1'b0}}, window_i});
  assign psum_sum  = {1'b0, psum_q} + {{(PsumW+1-PcpW){1'b0}}, ent_i.pcp};

  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      ts_q   <= cur_i.ts;
      tmin_q <= cur_i.temp;
      tmax_q <= cur_i.temp;
      hmin_q <= cur_i.hum;
      psum_q <= {{(PsumW-PcpW){1'b0}}, cur_i.pcp};
      cnt_q  <= CntW'(1);
    end else if (ctl_i.add) begin
      if ($signed(ent_i.temp) < $signed(tmin_q)) tmin_q <= ent_i.temp;
      if ($signed(ent_i.temp) > $signed(tmax_q)) tmax_q <= ent_i.temp;
      if (ent_i.hum < hmin_q) hmin_q <= ent_i.hum;
      psum_q <= (psum_sum > {1'b0, PsumMax}) ? PsumMax : psum_sum[PsumW-1:0];
      cnt_q  <= cnt_q + CntW'(1);
    end
  end

  assign tmin_o = tmin_q;
  assign tmax_o = tmax_q;
  assign hmin_o = hmin_q;
  assign psum_o = psum_q;
  assign cnt_o  = cnt_q;

endmodule

// File: hw/rtl/trailing_day_weather_summary_unit.sv
// Trailing-window weather summary: top level with history ring and walk sequencer.
//
// Input stream (s_axis_*): one weather observation per beat. Each beat is
// screened (humidity raised to the floor, range checks); a passing record is
// written into a ring of HISTORY_DEPTH entries held in a single RAM.
// Output stream (m_axis_*): one summary beat per input beat, tuser = accepted.
// A rejected record yields an all-zero summary and leaves the ring unchanged.
// Configuration: cfg_we_i writes register cfg_idx_i (0 window, 1 humidity
// floor, 2 solar limit) at the clock edge; write only while the unit is idle.
// Timing: an accepted record walks back one stored entry per cycle through
// the RAM read port, stopping at the first entry too old or at the fill
// level; a rejected record skips the walk. Input is taken only while the
// sequencer is idle.
// The summary is held in an output register; the next record is accepted
// while it waits, and the walk finishes and then holds until the receiver
// takes the pending beat.
// Reset clears ring pointer, fill level and configuration to defaults; the
// ring contents need no clearing as only written entries are ever read.
module trailing_day_weather_summary_unit
  import twsu_pkg::*;
#(
  parameter int unsigned HISTORY_DEPTH = HistDepthDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // timestamp[31:0], temperature[43:32], humidity[53:44],
  // precipitation[65:54], solar_radiation[77:66], zero pad
  input  logic [InDataW-1:0]  s_axis_tdata,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // min_temperature[11:0], max_temperature[23:12], min_humidity[33:24],
  // precipitation_sum[50:34], records_in_window[56:51], truncated[57], zero pad
  output logic [OutDataW-1:0] m_axis_tdata,
  // accepted[0]
  output logic [0:0]          m_axis_tuser,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i
);

  localparam int unsigned AW   = $clog2(HISTORY_DEPTH);
  localparam int unsigned CntW = $clog2(HISTORY_DEPTH + 1);
  localparam logic [AW-1:0]   LastAddr = AW'(HISTORY_DEPTH - 1);
  localparam logic [CntW-1:0] DepthCnt = CntW'(HISTORY_DEPTH);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_WALK = 2'd1;
  localparam logic [1:0] ST_OUT  = 2'd2;

  cfg_t     cfg;
  hist_t    cur_e, ent_e;
  acc_ctl_t acc_ctl;

  logic [1:0]      state_q, state_d;
  logic [AW-1:0]   wr_idx_q, wr_idx_d, rd_addr_q, rd_addr_d, rd_addr_prev, wr_prev;
  logic [CntW-1:0] fill_q, fill_d, fill_new, rem_q, rem_d;
  logic            ok_q, ok_d, trunc_q, trunc_d;
  logic            m_valid_q, m_valid_d;
  logic [OutDataW-1:0] m_data_q, m_data_d;
  logic            m_user_q, m_user_d;

  logic [HumW-1:0]   hum_in, hum_f;
  logic [SolarW-1:0] solar_in;
  logic              pass, in_beat, out_free;
  logic              ram_we, ram_re;
  logic [AW-1:0]     ram_raddr;
  logic [HistW-1:0]  ram_rdata;
  logic              too_old;
  logic [TempW-1:0]  tmin, tmax;
  logic [HumW-1:0]   hmin;
  logic [PsumW-1:0]  psum;
  logic [CntW-1:0]   cnt;
  logic [CntW+CntOutW-1:0] cnt_ext;

  twsu_cfg u_cfg (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_wdata_i,
    .cfg_o (cfg)
  );

  assign hum_in   = s_axis_tdata[53:44];
  assign solar_in = s_axis_tdata[77:66];
  assign hum_f    = (hum_in < cfg.hfloor) ? cfg.hfloor : hum_in;

  assign cur_e.ts   = s_axis_tdata[31:0];
  assign cur_e.temp = s_axis_tdata[43:32];
  assign cur_e.hum  = hum_f;
  assign cur_e.pcp  = s_axis_tdata[65:54];

  assign pass = ($signed(cur_e.temp) > TempLoExcl) && ($signed(cur_e.temp) < TempHiExcl)
             && (hum_f != '0) && (hum_f <= HumMax)
             && !solar_in[SolarW-1] && (solar_in[SlimW-1:0] <= cfg.slimit);

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_beat       = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_valid_q || m_axis_tready;

  assign wr_prev      = (wr_idx_q == '0) ? LastAddr : wr_idx_q - AW'(1);
  assign rd_addr_prev = (rd_addr_q == '0) ? LastAddr : rd_addr_q - AW'(1);
  assign fill_new     = (fill_q < DepthCnt) ? fill_q + CntW'(1) : fill_q;

  // walk reads never hit the entry written in the same cycle
  twsu_ram #(
    .Width (HistW),
    .Depth (HISTORY_DEPTH)
  ) u_ram (
    .clk_i,
    .we_i    (ram_we),
    .waddr_i (wr_idx_q),
    .wdata_i (cur_e),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign ent_e = hist_t'(ram_rdata);

  twsu_accum #(
    .HISTORY_DEPTH (HISTORY_DEPTH)
  ) u_accum (
    .clk_i,
    .ctl_i     (acc_ctl),
    .cur_i     (cur_e),
    .ent_i     (ent_e),
    .window_i  (cfg.window),
    .too_old_o (too_old),
    .tmin_o    (tmin),
    .tmax_o    (tmax),
    .hmin_o    (hmin),
    .psum_o    (psum),
    .cnt_o     (cnt)
  );

  assign cnt_ext = {{CntOutW{1'b0}}, cnt};

  always_comb begin
    state_d   = state_q;
    wr_idx_d  = wr_idx_q;
    rd_addr_d = rd_addr_q;
    fill_d    = fill_q;
    rem_d     = rem_q;
    ok_d      = ok_q;
    trunc_d   = trunc_q;
    m_valid_d = m_valid_q;
    m_data_d  = m_data_q;
    m_user_d  = m_user_q;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_raddr = rd_addr_prev;
    acc_ctl   = '0;

    if (m_valid_q && m_axis_tready) begin
      m_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        ram_raddr = wr_prev;
        if (in_beat) begin
          ok_d    = pass;
          trunc_d = 1'b0;
          state_d = ST_OUT;
          if (pass) begin
            ram_we       = 1'b1;
            acc_ctl.load = 1'b1;
            fill_d       = fill_new;
            wr_idx_d     = (wr_idx_q == LastAddr) ? '0 : wr_idx_q + AW'(1);
            if (fill_new > CntW'(1)) begin
              ram_re    = 1'b1;
              rd_addr_d = wr_prev;
              rem_d     = fill_new - CntW'(2);
              state_d   = ST_WALK;
            end else begin
              trunc_d = (fill_new == DepthCnt);
            end
          end
        end
      end
      ST_WALK: begin
        if (too_old) begin
          trunc_d = 1'b0;
          state_d = ST_OUT;
        end else begin
          acc_ctl.add = 1'b1;
          if (rem_q == '0) begin
            trunc_d = (fill_q == DepthCnt);
            state_d = ST_OUT;
          end else begin
            ram_re    = 1'b1;
            rd_addr_d = rd_addr_prev;
            rem_d     = rem_q - CntW'(1);
          end
        end
      end
      ST_OUT: begin
        if (out_free) begin
          m_valid_d = 1'b1;
          m_user_d  = ok_q;
          m_data_d  = ok_q ? {{(OutDataW-58){1'b0}}, trunc_q, cnt_ext[CntOutW-1:0],
                              psum, hmin, tmax, tmin} : '0;
          state_d   = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      wr_idx_q  <= '0;
      fill_q    <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      wr_idx_q  <= wr_idx_d;
      fill_q    <= fill_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_addr_q <= rd_addr_d;
    rem_q     <= rem_d;
    ok_q      <= ok_d;
    trunc_q   <= trunc_d;
    m_data_q  <= m_data_d;
    m_user_q  <= m_user_d;
  end

  assign m_axis_tvalid   = m_valid_q;
  assign m_axis_tdata    = m_data_q;
  assign m_axis_tuser[0] = m_user_q;

endmodule

// File: hw/rtl/twsu_checker.sv
// Port-level checks of the weather summary unit, bound to the top level.
module twsu_checker
  import twsu_pkg::*;
#(
  parameter int unsigned HISTORY_DEPTH = HistDepthDef
) (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                s_axis_tvalid,
  input logic                s_axis_tready,
  input logic [OutDataW-1:0] m_axis_tdata,
  input logic [0:0]          m_axis_tuser,
  input logic                m_axis_tvalid,
  input logic                m_axis_tready
);

  localparam logic [CntOutW-1:0] DepthCnt = CntOutW'(HISTORY_DEPTH % 64);

  // stalled beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("output beat changed while stalled");

  a_reject_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata == '0)
    else $error("rejected record with non-zero summary");

  a_min_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[0] |->
      $signed(m_axis_tdata[11:0]) <= $signed(m_axis_tdata[23:12]))
    else $error("window minimum above maximum");

  a_trunc_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[57] |->
      m_axis_tuser[0] && m_axis_tdata[56:51] == DepthCnt)
    else $error("truncated without a full ring");

  // accepting input while a result is still being produced would lose it
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("second record taken before the first completed");

endmodule

bind trailing_day_weather_summary_unit twsu_checker #(
  .HISTORY_DEPTH (HISTORY_DEPTH)
) u_twsu_checker (.*);
